// ===== rtl/bsp_pkg.sv =====
// shared types and constants for the bsp point cluster locator
package bsp_pkg;

  localparam int unsigned StackDepth = 1024;
  localparam int unsigned NodeCount  = 1024;
  localparam int unsigned LeafCount  = 1024;
  localparam int unsigned StackAw    = $clog2(StackDepth);
  localparam int unsigned PopLimit   = NodeCount + LeafCount;
  localparam int unsigned PopW       = $clog2(PopLimit + 1);
  localparam logic [15:0] EpsReset   = 16'd26;

  typedef enum logic [1:0] {
    FUNC_PLANE  = 2'd0,
    FUNC_NODE   = 2'd1,
    FUNC_LEAF   = 2'd2,
    FUNC_LOCATE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NO_LEAF  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_FETCH,
    S_READ,
    S_MUL,
    S_SUM,
    S_CMP,
    S_PUSH2
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // write tables from the input item
    logic init;      // latch point, push root
    logic pop;       // pop top of stack
    logic mul;       // register products
    logic sum;       // register distance
    logic push;      // first push per compare
    logic push2;     // back child of a dual push
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic limit;     // pop limit reached
    logic is_leaf;
    logic leaf_hit;
    logic node_ok;
    logic ovf;       // push would overflow
    logic both;      // point inside the band, both children go
  } stat_t;

endpackage

// ===== rtl/bsp_point_cluster_locator.sv =====
// top level of the bsp point cluster locator
// Load items (plane, node, leaf) give no result; busy stays low. A locate
// item walks the tree from node 0 with a stack in block memory: each
// popped leaf passes stack read, table read and decide, and each popped
// split node stack read, table read, plane read, three 32x16 products,
// distance sum, compare and push, plus a second push when the point lies
// in the band and both children are pushed; the final empty-stack or
// pop-limit check ends the walk. The result is registered and appears on
// cluster_o/status_o in the cycle after the deciding cycle, for one cycle
// with done_o; the receiver cannot stall, and busy_o is high from the
// cycle after acceptance through the done_o cycle. The user must write
// side_epsilon with cfg_we_i only while idle; the block does not enforce it.
module bsp_point_cluster_locator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic [9:0]         index_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] plane_offset_i,
  input  logic [9:0]         node_plane_i,
  input  logic signed [10:0] child_front_i,
  input  logic signed [10:0] child_back_i,
  input  logic signed [15:0] leaf_cluster_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [15:0] cluster_o,
  output logic [1:0]         status_o
);
  import bsp_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic [15:0]        eps_q;
  logic signed [15:0] leaf_val;
  logic               fin;
  logic [1:0]         fin_st;
  logic               busy_c;
  logic               start_go;
  logic               done_q;
  logic [15:0]        cl_q;
  logic [1:0]         st_q;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) eps_q <= EpsReset;
    else if (cfg_we_i) eps_q <= cfg_wdata_i;
  end

  // no item is taken during the result cycle
  assign start_go = start_i && !done_q;

  bsp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start_go), .func_i,
    .stat_i(stat), .cmd_o(cmd), .busy_o(busy_c),
    .done_o(fin), .status_o(fin_st)
  );

  bsp_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .func_i, .index_i,
    .vec_x_i, .vec_y_i, .vec_z_i, .plane_offset_i, .node_plane_i,
    .child_front_i, .child_back_i, .leaf_cluster_i,
    .eps_i(eps_q), .stat_o(stat), .leaf_o(leaf_val)
  );

  // result register, shown one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= fin;
  end
  always_ff @(posedge clk_i) begin
    if (fin) begin
      st_q <= fin_st;
      cl_q <= (fin_st == ST_FOUND) ? leaf_val : 16'hFFFF;
    end
  end

  // busy covers the result cycle too
  assign busy_o    = busy_c || done_q;
  assign done_o    = done_q;
  assign cluster_o = cl_q;
  assign status_o  = st_q;

endmodule

// ===== rtl/bsp_ctrl.sv =====
// walk sequencer for the bsp point cluster locator
module bsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    func_i,
  input  bsp_pkg::stat_t stat_i,
  output bsp_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o,
  output logic [1:0]    status_o
);
  import bsp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    done_o   = 1'b0;
    status_o = ST_NO_LEAF;
    busy_o   = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (func_i == FUNC_LOCATE) begin
            cmd_o.init = 1'b1;
            state_d    = S_POP;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_POP: begin
        if (stat_i.empty || stat_i.limit) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_READ;
      end
      S_READ: begin
        if (stat_i.is_leaf) begin
          if (stat_i.leaf_hit) begin
            done_o   = 1'b1;
            status_o = ST_FOUND;
            state_d  = S_IDLE;
          end else begin
            state_d = S_POP;
          end
        end else if (stat_i.node_ok) begin
          state_d = S_MUL;
        end else begin
          state_d = S_POP;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (stat_i.ovf) begin
          done_o   = 1'b1;
          status_o = ST_OVERFLOW;
          state_d  = S_IDLE;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = stat_i.both ? S_PUSH2 : S_POP;
        end
      end
      S_PUSH2: begin
        cmd_o.push2 = 1'b1;
        state_d     = S_POP;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/bsp_dp.sv =====
// tables, walk stack and distance datapath
module bsp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsp_pkg::cmd_t       cmd_i,
  input  logic [1:0]          func_i,
  input  logic [9:0]          index_i,
  input  logic signed [31:0]  vec_x_i,
  input  logic signed [31:0]  vec_y_i,
  input  logic signed [31:0]  vec_z_i,
  input  logic signed [31:0]  plane_offset_i,
  input  logic [9:0]          node_plane_i,
  input  logic signed [10:0]  child_front_i,
  input  logic signed [10:0]  child_back_i,
  input  logic signed [15:0]  leaf_cluster_i,
  input  logic [15:0]         eps_i,
  output bsp_pkg::stat_t      stat_o,
  output logic signed [15:0]  leaf_o
);
  import bsp_pkg::*;

  logic [47:0] norm_mem [1024];
  logic [31:0] off_mem  [1024];
  logic [31:0] node_mem [1024];
  logic [15:0] leaf_mem [1024];
  logic [10:0] stk_mem  [StackDepth];

  logic [StackAw:0]    lvl_q, lvl_d;
  logic [PopW-1:0]     pops_q;
  logic signed [31:0]  px_q, py_q, pz_q;
  logic signed [10:0]  top_q;
  logic [47:0]         norm_q;
  logic [31:0]         off_q, node_q;
  logic [15:0]         leaf_q;
  logic signed [47:0]  mx_q, my_q, mz_q;
  logic signed [49:0]  moff_q;
  logic signed [49:0]  d_q;
  logic signed [49:0]  eps_s;
  logic                go_front, go_back;
  logic                stk_we;
  logic [StackAw-1:0]  stk_waddr;
  logic [10:0]         stk_wdata;

  // one level change per cycle
  always_comb begin
    lvl_d = lvl_q;
    if (cmd_i.init) lvl_d = (StackAw+1)'(1);
    else if (cmd_i.pop) lvl_d = lvl_q - (StackAw+1)'(1);
    else if (cmd_i.push || cmd_i.push2) lvl_d = lvl_q + (StackAw+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q  <= '0;
      pops_q <= '0;
    end else begin
      lvl_q <= lvl_d;
      if (cmd_i.init) pops_q <= '0;
      else if (cmd_i.pop) pops_q <= pops_q + PopW'(1);
    end
  end

  // single stack write port; a dual push writes front, then back in the next cycle
  always_comb begin
    stk_we    = cmd_i.init || cmd_i.push || cmd_i.push2;
    stk_waddr = lvl_q[StackAw-1:0];
    stk_wdata = node_q[31:21];
    if (cmd_i.init) begin
      stk_waddr = '0;
      stk_wdata = '0;
    end else if (cmd_i.push && go_front) begin
      stk_wdata = node_q[20:10];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (cmd_i.pop) top_q <= stk_mem[lvl_q[StackAw-1:0] - StackAw'(1)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      unique case (func_e'(func_i))
        FUNC_PLANE: begin
          norm_mem[index_i] <= {vec_z_i[15:0], vec_y_i[15:0], vec_x_i[15:0]};
          off_mem[index_i]  <= plane_offset_i;
        end
        FUNC_NODE:  node_mem[index_i] <= {child_back_i, child_front_i, node_plane_i};
        FUNC_LEAF:  leaf_mem[index_i] <= leaf_cluster_i;
        default: ;
      endcase
    end
    if (cmd_i.init) begin
      px_q <= vec_x_i;
      py_q <= vec_y_i;
      pz_q <= vec_z_i;
    end
  end

  // table reads keyed by popped entry, then by its plane
  always_ff @(posedge clk_i) begin
    node_q <= node_mem[top_q[9:0]];
    leaf_q <= leaf_mem[~top_q[9:0]];
  end
  always_ff @(posedge clk_i) begin
    norm_q <= norm_mem[node_q[9:0]];
    off_q  <= off_mem[node_q[9:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      mx_q   <= px_q * $signed(norm_q[15:0]);
      my_q   <= py_q * $signed(norm_q[31:16]);
      mz_q   <= pz_q * $signed(norm_q[47:32]);
      moff_q <= {{4{off_q[31]}}, off_q, 14'd0};
    end
    if (cmd_i.sum) d_q <= 50'(mx_q) + 50'(my_q) + 50'(mz_q) - moff_q;
  end

  assign eps_s    = $signed({20'd0, eps_i, 14'd0});
  assign go_front = !(d_q < -eps_s);
  assign go_back  = !(d_q > eps_s);

  assign stat_o.empty    = (lvl_q == '0);
  assign stat_o.limit    = (pops_q >= PopW'(PopLimit));
  assign stat_o.is_leaf  = top_q[10];
  assign stat_o.leaf_hit = (leaf_q != 16'hFFFF);
  assign stat_o.node_ok  = 1'b1;
  assign stat_o.ovf      = ((go_front && go_back) ? 32'(lvl_q) + 32'd2 : 32'(lvl_q) + 32'd1)
                           >= 32'(StackDepth);
  assign stat_o.both     = go_front && go_back;
  assign leaf_o = leaf_q;

endmodule
